// ===== src/least_loaded_stick_assigner_core_assert.svh =====
// ----------------------------------------------------------------------------
// least_loaded_stick_assigner_core_assert
// assertion macros shared by the stick assigner rtl
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_STICK_ASSIGNER_CORE_ASSERT_SVH
`define LEAST_LOADED_STICK_ASSIGNER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LLSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LLSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/llsa_pkg.sv =====
// ----------------------------------------------------------------------------
// llsa_pkg
// shared types and constants of the least-loaded stick assigner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llsa_pkg;

  localparam int CORES     = 16;
  localparam int CORE_W    = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int PW_W      = 25;
  localparam int ST_W      = 17;
  localparam int OFS_W     = 25;
  localparam int PROD_W    = ST_W + 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [PW_W-1:0]  PW_MAX  = {PW_W{1'b1}};
  localparam logic [ST_W-1:0]  ST_MAX  = {ST_W{1'b1}};
  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

  localparam logic FUNC_PLACE  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NZ = 1'b1;

  localparam logic [CFG_W-1:0] GRID_RESET = 9'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic              vld;
    logic              rpt;   // report transaction
    logic              qok;   // queried core exists
    logic              done;  // empty core found, search frozen
    logic [CORE_W-1:0] idx;   // current candidate or queried core
    logic [PW_W-1:0]   bp;    // candidate plane-wave load
    logic [ST_W-1:0]   bs;    // candidate stick load
    logic [OFS_W-1:0]  ofs;   // start offset of candidate
    logic [OFS_W-1:0]  sum;   // running prefix of sticks times nz
  } tok_t;

  // load write-back to the winning cell
  typedef struct packed {
    logic              en;
    logic [CORE_W-1:0] idx;
    logic [PW_W-1:0]   pw;
    logic [ST_W-1:0]   st;
  } upd_t;

endpackage

// ===== src/llsa_cell.sv =====
// ----------------------------------------------------------------------------
// llsa_cell
// one core's load registers plus one stage of the search chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llsa_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [llsa_pkg::CORE_W-1:0]  cell_idx,
  input  logic [llsa_pkg::CFG_W-1:0]   grid_nz,
  input  llsa_pkg::tok_t               tok_i,
  output llsa_pkg::tok_t               tok_o,
  input  llsa_pkg::upd_t               upd_i,
  output logic [llsa_pkg::PW_W-1:0]    pw_o,
  output logic [llsa_pkg::ST_W-1:0]    st_o
);
  import llsa_pkg::*;

  logic [PW_W-1:0]   pw_r;
  logic [ST_W-1:0]   st_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic [OFS_W+1:0]  sum_ext;
  logic              better;
  logic              here;

  // this core's contribution to the start offsets of higher cores
  assign prod_nxt = PROD_W'(st_r) * PROD_W'(grid_nz);
  assign sum_ext  = (OFS_W+2)'(tok_i.sum) + (OFS_W+2)'(prod_r);
  assign here     = (tok_i.idx == cell_idx);
  assign better   = !tok_i.done &&
                    ((pw_r == '0) || (pw_r < tok_i.bp) ||
                     ((pw_r == tok_i.bp) && (st_r < tok_i.bs)));

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.sum = (sum_ext > (OFS_W+2)'(OFS_MAX)) ? OFS_MAX : sum_ext[OFS_W-1:0];
    if (tok_i.rpt) begin
      if (tok_i.qok && here) begin
        tok_nxt.bp  = pw_r;
        tok_nxt.bs  = st_r;
        tok_nxt.ofs = tok_i.sum;
      end
    end else if (better) begin
      tok_nxt.idx  = cell_idx;
      tok_nxt.bp   = pw_r;
      tok_nxt.bs   = st_r;
      tok_nxt.ofs  = tok_i.sum;
      tok_nxt.done = tok_i.done | (pw_r == '0);
    end else if (here) begin
      tok_nxt.ofs = tok_i.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r      <= '0;
      st_r      <= '0;
      prod_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      prod_r <= prod_nxt;
      tok_r  <= tok_nxt;
      if (upd_i.en && (upd_i.idx == cell_idx)) begin
        pw_r <= upd_i.pw;
        st_r <= upd_i.st;
      end
    end
  end

  assign tok_o = tok_r;
  assign pw_o  = pw_r;
  assign st_o  = st_r;

endmodule

// ===== src/least_loaded_stick_assigner_core.sv =====
// ----------------------------------------------------------------------------
// least_loaded_stick_assigner_core: greedy least-loaded stick placement
// flow: one transaction in flight, in_stall holds off the next one until the
//   result is loaded into the output register; the token walks one cell of the
//   core chain per cycle
// reset: synchronous rst_n clears all loads, last choice, grid sizes to 64
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "least_loaded_stick_assigner_core_assert.svh"

module least_loaded_stick_assigner_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [llsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llsa_pkg::CFG_W-1:0]     cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [7:0]                     in_stick_x,
  input  logic [7:0]                     in_stick_y,
  input  logic [8:0]                     in_stick_len,
  input  logic [3:0]                     in_query_core,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_assigned_core,
  output logic [15:0]                    out_grid_index,
  output logic [24:0]                    out_core_pw_total,
  output logic [16:0]                    out_core_stick_total,
  output logic [24:0]                    out_core_start_offset
);
  import llsa_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  ny_r;
  logic [CFG_W-1:0]  nz_r;

  // control
  state_t            state_r;
  state_t            state_nxt;
  logic [CORE_W-1:0] last_choice_r;
  logic              in_acc;
  logic              fin;
  logic              out_free;
  logic              out_load;

  // captured transaction fields
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic [8:0]        len_r;
  logic [3:0]        q_r;

  // cell chain: tok_chain[c] feeds cell c, tok_chain[CORES] leaves the last cell
  tok_t              tok0_r;
  tok_t              tok0_nxt;
  tok_t              tok_chain [CORES+1];
  tok_t              hold_r;
  tok_t              src;
  upd_t              upd;
  logic [PW_W-1:0]   pw_arr [CORES];
  logic [ST_W-1:0]   st_arr [CORES];
  logic [CORES:0]    tok_vld;

  // result datapath
  logic [PW_W:0]     pw_sum;
  logic [PW_W-1:0]   new_pw;
  logic [ST_W-1:0]   new_st;
  logic [17:0]       gi_full;
  logic [3:0]        res_core;
  logic [15:0]       res_grid;
  logic [PW_W-1:0]   res_pw;
  logic [ST_W-1:0]   res_st;

  // output register
  logic              out_valid_r;
  logic [3:0]        out_core_r;
  logic [15:0]       out_grid_r;
  logic [PW_W-1:0]   out_pw_r;
  logic [ST_W-1:0]   out_st_r;
  logic [OFS_W-1:0]  out_ofs_r;

  // --------------------------------------------------------------------------
  // configuration, to be written only while idle; the block does not enforce it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ny_r <= GRID_RESET;
      nz_r <= GRID_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRID_NY: ny_r <= cfg_wr_data;
        CFG_GRID_NZ: nz_r <= cfg_wr_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control: one transaction in flight, token launch, finish, output hold
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fin      = (state_r == ST_SCAN) && tok_chain[CORES].vld;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (fin) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // token launch: a place search starts with the last choice as candidate, a report with the queried core
  always_comb begin
    tok0_nxt     = tok0_r;
    tok0_nxt.vld = 1'b0;
    if (in_acc) begin
      tok0_nxt.vld  = 1'b1;
      tok0_nxt.done = 1'b0;
      tok0_nxt.ofs  = '0;
      tok0_nxt.sum  = '0;
      if (in_func == FUNC_REPORT) begin
        tok0_nxt.rpt = 1'b1;
        tok0_nxt.qok = (32'(in_query_core) < CORES);
        tok0_nxt.idx = CORE_W'(in_query_core);
        tok0_nxt.bp  = '0;
        tok0_nxt.bs  = '0;
      end else begin
        tok0_nxt.rpt = 1'b0;
        tok0_nxt.qok = 1'b0;
        tok0_nxt.idx = last_choice_r;
        tok0_nxt.bp  = pw_arr[last_choice_r];
        tok0_nxt.bs  = st_arr[last_choice_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_choice_r <= '0;
      tok0_r.vld    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tok0_r  <= tok0_nxt;
      if (fin && !tok_chain[CORES].rpt) last_choice_r <= tok_chain[CORES].idx;
    end
  end

  // transaction payload and parked token
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_stick_x;
      y_r   <= in_stick_y;
      len_r <= in_stick_len;
      q_r   <= in_query_core;
    end
    if (fin) hold_r <= tok_chain[CORES];
  end

  // --------------------------------------------------------------------------
  // cell chain, token advances one core per cycle
  // --------------------------------------------------------------------------
  assign tok_chain[0] = tok0_r;
  assign tok_vld[0]   = tok0_r.vld;

  for (genvar c = 0; c < CORES; c++) begin : g_cell
    llsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CORE_W'(c)),
      .grid_nz  (nz_r),
      .tok_i    (tok_chain[c]),
      .tok_o    (tok_chain[c+1]),
      .upd_i    (upd),
      .pw_o     (pw_arr[c]),
      .st_o     (st_arr[c])
    );
    assign tok_vld[c+1] = tok_chain[c+1].vld;
  end

  // --------------------------------------------------------------------------
  // result and write-back, from the finishing token or the parked one
  // --------------------------------------------------------------------------
  assign src = (state_r == ST_HOLD) ? hold_r : tok_chain[CORES];

  // saturating load updates of the winner
  assign pw_sum  = (PW_W+1)'(src.bp) + (PW_W+1)'(len_r);
  assign new_pw  = (pw_sum > (PW_W+1)'(PW_MAX)) ? PW_MAX : pw_sum[PW_W-1:0];
  assign new_st  = (src.bs == ST_MAX) ? src.bs : src.bs + 1'b1;

  // flat grid index keeps the low 16 bits
  assign gi_full = 18'(x_r) * 18'(ny_r) + 18'(y_r);

  assign res_core = src.rpt ? q_r : 4'(src.idx);
  assign res_grid = src.rpt ? 16'd0 : gi_full[15:0];
  assign res_pw   = src.rpt ? src.bp : new_pw;
  assign res_st   = src.rpt ? src.bs : new_st;

  always_comb begin
    upd     = '0;
    upd.en  = fin && !tok_chain[CORES].rpt;
    upd.idx = src.idx;
    upd.pw  = new_pw;
    upd.st  = new_st;
  end

  // --------------------------------------------------------------------------
  // output register, frees the search while a result waits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_core_r <= res_core;
      out_grid_r <= res_grid;
      out_pw_r   <= res_pw;
      out_st_r   <= res_st;
      out_ofs_r  <= src.ofs;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_assigned_core     = out_core_r;
  assign out_grid_index        = out_grid_r;
  assign out_core_pw_total     = out_pw_r;
  assign out_core_stick_total  = out_st_r;
  assign out_core_start_offset = out_ofs_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `LLSA_ASSERT_NOW(a_single_token, 1'b1, $countones(tok_vld) <= 1,
    "more than one search token in the cell chain")
  `LLSA_ASSERT_NEXT(a_launch, in_acc, tok0_r.vld && (state_r == ST_SCAN),
    "accepted transaction did not launch a search token")
  `LLSA_ASSERT_NEXT(a_last_choice, fin && !tok_chain[CORES].rpt,
    last_choice_r == $past(tok_chain[CORES].idx),
    "last choice not updated to the placed core")
  `LLSA_ASSERT_NOW(a_hold_busy, state_r == ST_HOLD, out_valid_r,
    "result parked while the output register is empty")

endmodule
